// ===== src/kbd_pkg.sv =====
// Shared types, operation codes and the set-1 to ASCII translation function.
package kbd_pkg;

  // Operation codes carried on in_func.
  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ASCII_W = 7;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;     // a transaction is taken this cycle
    logic rd_issue;   // pop of a stored code: read the buffer, advance the read pointer
    logic xlat_done;  // buffer read data is valid: translate and present it
  } kbd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pop_req;    // the offered transaction is a pop
    logic has_code;   // the buffer holds at least one code
  } kbd_sts_t;

  // Set-1 make codes to ASCII. Letters come out in upper case and the space code
  // gives a blank; every code outside the table gives zero.
  function automatic logic [ASCII_W-1:0] kbd_xlate(input logic [CODE_W-1:0] code);
    logic [ASCII_W-1:0] ch;
    case (code)
      8'h02: ch = 7'h31;  8'h03: ch = 7'h32;  8'h04: ch = 7'h33;  8'h05: ch = 7'h34;
      8'h06: ch = 7'h35;  8'h07: ch = 7'h36;  8'h08: ch = 7'h37;  8'h09: ch = 7'h38;
      8'h0A: ch = 7'h39;  8'h0B: ch = 7'h30;  8'h0C: ch = 7'h2D;  8'h0D: ch = 7'h3D;
      8'h0E: ch = 7'h08;  8'h0F: ch = 7'h09;  8'h10: ch = 7'h51;  8'h11: ch = 7'h57;
      8'h12: ch = 7'h45;  8'h13: ch = 7'h52;  8'h14: ch = 7'h54;  8'h15: ch = 7'h59;
      8'h16: ch = 7'h55;  8'h17: ch = 7'h49;  8'h18: ch = 7'h4F;  8'h19: ch = 7'h50;
      8'h1A: ch = 7'h5B;  8'h1B: ch = 7'h5D;  8'h1C: ch = 7'h0A;  8'h1E: ch = 7'h41;
      8'h1F: ch = 7'h53;  8'h20: ch = 7'h44;  8'h21: ch = 7'h46;  8'h22: ch = 7'h47;
      8'h23: ch = 7'h48;  8'h24: ch = 7'h4A;  8'h25: ch = 7'h4B;  8'h26: ch = 7'h4C;
      8'h27: ch = 7'h3B;  8'h28: ch = 7'h27;  8'h29: ch = 7'h7E;  8'h2B: ch = 7'h5C;
      8'h2C: ch = 7'h5A;  8'h2D: ch = 7'h58;  8'h2E: ch = 7'h43;  8'h2F: ch = 7'h56;
      8'h30: ch = 7'h42;  8'h31: ch = 7'h4E;  8'h32: ch = 7'h4D;  8'h33: ch = 7'h2C;
      8'h34: ch = 7'h2E;  8'h35: ch = 7'h2F;  8'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/keyboard_scancode_fifo_decoder.sv =====
// Top level of the keyboard scan-code buffer with set-1 to ASCII translation.
//
// A transaction is taken at a rising edge where start is high and busy is low.
// in_func selects the operation: push stores in_scan_code in a circular buffer
// of DEPTH slots that holds at most DEPTH-1 codes (a push into a full buffer is
// discarded and reported through out_dropped); pop removes the oldest code and
// returns its upper-case ASCII translation with out_char_valid set (an empty
// buffer gives out_char_valid low and a zero character); status and the unused
// code only report. Every transaction produces exactly one result, shown for a
// single cycle with out_strobe high, the cycle after the work finishes; the
// receiver has no way to stall it, so it must take each result when the strobe
// is high. Push, status and empty pops leave busy low, so the next transaction
// may follow at once. A pop of a stored code raises busy while it translates,
// because the code buffer is a RAM with a registered read port: the accept
// cycle reads the slot and the ST_XLAT state then runs the translation table
// on the read data. out_fifo_nonempty tells whether the buffer still holds a
// code after the transaction. The buffer contents need no clearing after
// reset; only the pointers and the strobe are reset.
module keyboard_scancode_fifo_decoder import kbd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [CODE_W-1:0]  in_scan_code,
  output logic               out_strobe,
  output logic [ASCII_W-1:0] out_ascii_char,
  output logic               out_char_valid,
  output logic               out_dropped,
  output logic               out_fifo_nonempty
);

  kbd_cmd_t cmd;
  kbd_sts_t sts;

  // The controller decides when a transaction is taken and whether a pop
  // needs the translation state.
  kbd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath owns the buffer, its pointers and the registered result.
  kbd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_func),
    .in_scan_code      (in_scan_code),
    .cmd               (cmd),
    .sts               (sts),
    .out_strobe        (out_strobe),
    .out_ascii_char    (out_ascii_char),
    .out_char_valid    (out_char_valid),
    .out_dropped       (out_dropped),
    .out_fifo_nonempty (out_fifo_nonempty)
  );

endmodule

// ===== src/kbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/kbd_ctrl.sv =====
// Controller state machine: takes transactions and sequences the pop read.
module kbd_ctrl import kbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  kbd_sts_t sts,
  output kbd_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_XLAT = 2'b10
  } kbd_state_t;

  kbd_state_t state_r, state_nxt;

  always_comb begin
    cmd.accept    = (state_r == ST_IDLE) && start;
    cmd.rd_issue  = cmd.accept && sts.pop_req && sts.has_code;
    cmd.xlat_done = (state_r == ST_XLAT);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.rd_issue) begin
          state_nxt = ST_XLAT;
        end
      end
      ST_XLAT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== src/kbd_dp.sv =====
// Datapath: circular code buffer, pointers, translation and result registers.
module kbd_dp import kbd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_func,
  input  logic [CODE_W-1:0]  in_scan_code,
  input  kbd_cmd_t           cmd,
  output kbd_sts_t           sts,
  output logic               out_strobe,
  output logic [ASCII_W-1:0] out_ascii_char,
  output logic               out_char_valid,
  output logic               out_dropped,
  output logic               out_fifo_nonempty
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_inc, wr_inc;
  logic          is_push, full, has_code, push_ok;
  logic [CODE_W-1:0] ram_rdata;

  logic               strobe_r, strobe_nxt;
  logic [ASCII_W-1:0] ascii_r, ascii_nxt;
  logic               valid_r, valid_nxt;
  logic               dropped_r, dropped_nxt;
  logic               nonempty_r, nonempty_nxt;

  assign rd_inc   = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc   = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
  assign is_push  = (in_func == FUNC_PUSH);
  assign full     = (wr_inc == rd_ptr_r);
  assign has_code = (rd_ptr_r != wr_ptr_r);
  assign push_ok  = cmd.accept && is_push && !full;

  assign sts.pop_req  = (in_func == FUNC_POP);
  assign sts.has_code = has_code;

  kbd_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wr_ptr_r),
    .wdata (in_scan_code),
    .re    (cmd.rd_issue),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_ptr_nxt = cmd.rd_issue ? rd_inc : rd_ptr_r;
    wr_ptr_nxt = push_ok ? wr_inc : wr_ptr_r;
  end

  always_comb begin
    strobe_nxt   = 1'b0;
    ascii_nxt    = ascii_r;
    valid_nxt    = valid_r;
    dropped_nxt  = dropped_r;
    nonempty_nxt = nonempty_r;
    if (cmd.xlat_done) begin
      strobe_nxt   = 1'b1;
      ascii_nxt    = kbd_xlate(ram_rdata);
      valid_nxt    = 1'b1;
      dropped_nxt  = 1'b0;
      nonempty_nxt = has_code;
    end else if (cmd.accept && !cmd.rd_issue) begin
      // Push, status, or a pop of an empty buffer finishes at once.
      strobe_nxt   = 1'b1;
      ascii_nxt    = '0;
      valid_nxt    = 1'b0;
      dropped_nxt  = is_push && full;
      nonempty_nxt = push_ok || has_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ascii_r    <= ascii_nxt;
    valid_r    <= valid_nxt;
    dropped_r  <= dropped_nxt;
    nonempty_r <= nonempty_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_ascii_char    = ascii_r;
  assign out_char_valid    = valid_r;
  assign out_dropped       = dropped_r;
  assign out_fifo_nonempty = nonempty_r;

endmodule

// ===== src/kbd_chk.sv =====
// Port-level assertions for the keyboard buffer and their bind to the top level.
module kbd_chk import kbd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic [ASCII_W-1:0] out_ascii_char,
  input logic               out_char_valid,
  input logic               out_dropped,
  input logic               out_fifo_nonempty
);

  // A taken transaction either reports at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe || busy)
    else $error("transaction neither reported nor in progress");

  // The busy state of a pop always ends with its result.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe && out_char_valid && !busy)
    else $error("pop did not complete after its busy cycle");

  // A dropped push means the buffer was full, hence not empty.
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_dropped |-> out_fifo_nonempty && !out_char_valid)
    else $error("drop reported with empty buffer or a character");

  // No popped code means no character.
  a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_char_valid |-> out_ascii_char == '0)
    else $error("character reported without a popped code");

endmodule

bind keyboard_scancode_fifo_decoder kbd_chk u_kbd_chk (.*);
